// ===== hdl/rsn_pkg.sv =====
// rsn_pkg: shared types and constants for the record sort block.
// No dependencies.
package rsn_pkg;

    localparam int NameW = 64;
    localparam int IdW   = 32;
    localparam int PosW  = 5;
    localparam int WidxW = 3;

    localparam logic [WidxW-1:0] WidxFirst = '0;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RDI,
        ST_GETI,
        ST_RDJ,
        ST_GETB,
        ST_CMP,
        ST_CMPW,
        ST_SWAP,
        ST_NEXTJ,
        ST_ERD,
        ST_EGET,
        ST_EOUT,
        ST_EWAIT
    } state_t;

    typedef struct packed {
        logic gt;
        logic done;
    } cmp_res_t;

endpackage

// ===== hdl/rsn_word_cmp.sv =====
// rsn_word_cmp: bytewise unsigned compare of one 8-byte name word pair.
// Depends on rsn_pkg.
module rsn_word_cmp (
    input  logic [rsn_pkg::NameW-1:0] word_a,
    input  logic [rsn_pkg::NameW-1:0] word_b,
    output rsn_pkg::cmp_res_t         res
);
    import rsn_pkg::*;

    always_comb begin
        logic [7:0] xa;
        logic [7:0] xb;
        logic       found;
        res   = '0;
        found = 1'b0;
        for (int k = 0; k < 8; k++) begin
            xa = word_a[NameW-1-8*k -: 8];
            xb = word_b[NameW-1-8*k -: 8];
            if (!found) begin
                if (xa != xb) begin
                    found    = 1'b1;
                    res.gt   = (xa > xb);
                    res.done = 1'b1;
                end else if (xa == 8'd0) begin
                    found    = 1'b1;
                    res.done = 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/rsn_name_store.sv =====
// rsn_name_store: name word memory, one write and two registered read ports,
// with per-word valid bits so unwritten words read as zero. Depends on rsn_pkg.
module rsn_name_store #(
    parameter int MAX_RECORDS = 32,
    parameter int NAME_WORDS  = 7,
    parameter int SW          = 5,
    parameter int WW          = 3
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      wr_en,
    input  logic                      wr_open,
    input  logic [SW-1:0]             wr_rec,
    input  logic [WW-1:0]             wr_word,
    input  logic [rsn_pkg::NameW-1:0] wr_data,
    input  logic [SW-1:0]             rd_rec_a,
    input  logic [SW-1:0]             rd_rec_b,
    input  logic [WW-1:0]             rd_word,
    output logic [rsn_pkg::NameW-1:0] rd_data_a,
    output logic [rsn_pkg::NameW-1:0] rd_data_b
);
    import rsn_pkg::*;

    localparam int Depth = MAX_RECORDS * NAME_WORDS;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

    logic [NameW-1:0] mem [Depth];
    logic [Depth-1:0] vld_reg;
    logic [NameW-1:0] rd_a_reg, rd_b_reg;
    logic             va_reg, vb_reg;
    logic [AW-1:0]    wr_addr, ra_addr, rb_addr;

    assign wr_addr = AW'(32'(wr_rec) * 32'(NAME_WORDS) + 32'(wr_word));
    assign ra_addr = AW'(32'(rd_rec_a) * 32'(NAME_WORDS) + 32'(rd_word));
    assign rb_addr = AW'(32'(rd_rec_b) * 32'(NAME_WORDS) + 32'(rd_word));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[ra_addr];
        rd_b_reg <= mem[rb_addr];
    end

    // opening write lands on word 0 of the record; the rest of it reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
        end else begin
            va_reg <= vld_reg[ra_addr];
            vb_reg <= vld_reg[rb_addr];
            if (wr_en) begin
                if (wr_open) begin
                    for (int r = 0; r < MAX_RECORDS; r++) begin
                        if (SW'(r) == wr_rec) begin
                            for (int w = 0; w < NAME_WORDS; w++) begin
                                vld_reg[r*NAME_WORDS+w] <= (w == 0);
                            end
                        end
                    end
                end else begin
                    vld_reg[wr_addr] <= 1'b1;
                end
            end
        end
    end

    assign rd_data_a = va_reg ? rd_a_reg : '0;
    assign rd_data_b = vb_reg ? rd_b_reg : '0;

endmodule

// ===== hdl/record_sort_by_name.sv =====
// record_sort_by_name: loads records (one name word per cycle, ready high in load),
// then exchange-sorts them through one shared word compare unit and emits them.
// Sort: per i RDI, GETI; per (i,j) pair RDJ, GETB, CMP/CMPW per word, SWAP on swap, NEXTJ.
// Emit: ERD, EGET, EOUT, EWAIT till m_ready; the first load word follows the last result.
// Reset: synchronous, active low; clears the record count, flags and name valid bits, no sweep.
// Depends on rsn_pkg, rsn_name_store, rsn_word_cmp.
module record_sort_by_name #(
    parameter int MAX_RECORDS = 32,
    parameter int NAME_WORDS  = 7
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rsn_pkg::NameW-1:0]        s_name_word,
    input  logic [rsn_pkg::WidxW-1:0]        s_word_index,
    input  logic signed [rsn_pkg::IdW-1:0]   s_record_id,
    input  logic signed [rsn_pkg::IdW-1:0]   s_record_status,
    input  logic                             s_record_end,
    input  logic                             s_set_end,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rsn_pkg::PosW-1:0]         m_load_position,
    output logic signed [rsn_pkg::IdW-1:0]   m_out_id,
    output logic signed [rsn_pkg::IdW-1:0]   m_out_status,
    output logic                             m_last_result,
    output logic                             m_dropped
);
    import rsn_pkg::*;

    localparam int SW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int WW = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
    localparam logic [WW-1:0] WLast = WW'(NAME_WORDS - 1);

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg;
    logic          ovf_reg, open_reg;
    logic [SW-1:0] i_reg, j_reg, cur_reg, b_reg, slot_reg;
    logic [WW-1:0] k_reg;

    logic [SW-1:0] perm_mem [MAX_RECORDS];
    logic [IdW-1:0] id_mem [MAX_RECORDS];
    logic [IdW-1:0] st_mem [MAX_RECORDS];
    logic [SW-1:0] perm_q;
    logic [IdW-1:0] id_q, st_q;

    logic          perm_we;
    logic [SW-1:0] perm_wa, perm_wd, perm_ra;

    logic          m_valid_reg, m_last_reg, m_drop_reg;
    logic [PosW-1:0] m_pos_reg;
    logic [IdW-1:0] m_id_reg, m_st_reg;

    logic          accept, widx_zero, in_range, room, load_new;
    logic          nm_we;
    logic [SW-1:0] nm_rec;
    logic [CW-1:0] count_after;
    logic          j_last, i_last, emit_last;
    logic [NameW-1:0] word_a, word_b;
    cmp_res_t      cmp_res;

    assign accept    = s_valid && s_ready;
    assign widx_zero = (s_word_index == WidxFirst);
    assign in_range  = (32'(s_word_index) < 32'(NAME_WORDS));
    assign room      = (count_reg < CW'(MAX_RECORDS));
    assign load_new  = accept && widx_zero && room;
    assign nm_we     = accept && (widx_zero ? room
                                : (open_reg && (count_reg != '0) && in_range));
    assign nm_rec    = widx_zero ? SW'(count_reg) : SW'(count_reg - CW'(1));
    assign count_after = load_new ? count_reg + CW'(1) : count_reg;
    assign j_last    = (CW'(j_reg) == count_reg - CW'(1));
    assign i_last    = (CW'(i_reg) == count_reg - CW'(2));
    assign emit_last = (CW'(i_reg) == count_reg - CW'(1));

    rsn_name_store #(
        .MAX_RECORDS(MAX_RECORDS),
        .NAME_WORDS (NAME_WORDS),
        .SW         (SW),
        .WW         (WW)
    ) u_names (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (nm_we),
        .wr_open  (widx_zero),
        .wr_rec   (nm_rec),
        .wr_word  (WW'(s_word_index)),
        .wr_data  (s_name_word),
        .rd_rec_a (cur_reg),
        .rd_rec_b (b_reg),
        .rd_word  (k_reg),
        .rd_data_a(word_a),
        .rd_data_b(word_b)
    );

    rsn_word_cmp u_cmp (
        .word_a(word_a),
        .word_b(word_b),
        .res   (cmp_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept && s_set_end) begin
                    if (count_after > CW'(1)) begin
                        state_next = ST_RDI;
                    end else if (count_after == CW'(1)) begin
                        state_next = ST_ERD;
                    end
                end
            end
            ST_RDI:   state_next = ST_GETI;
            ST_GETI:  state_next = ST_RDJ;
            ST_RDJ:   state_next = ST_GETB;
            ST_GETB:  state_next = ST_CMP;
            ST_CMP:   state_next = ST_CMPW;
            ST_CMPW: begin
                if (cmp_res.gt) begin
                    state_next = ST_SWAP;
                end else if (cmp_res.done || k_reg == WLast) begin
                    state_next = ST_NEXTJ;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_SWAP:  state_next = ST_NEXTJ;
            ST_NEXTJ: begin
                if (!j_last) begin
                    state_next = ST_RDJ;
                end else if (i_last) begin
                    state_next = ST_ERD;
                end else begin
                    state_next = ST_RDI;
                end
            end
            ST_ERD:   state_next = ST_EGET;
            ST_EGET:  state_next = ST_EOUT;
            ST_EOUT:  state_next = ST_EWAIT;
            ST_EWAIT: begin
                if (m_ready) begin
                    state_next = emit_last ? ST_LOAD : ST_ERD;
                end
            end
            default:  state_next = ST_LOAD;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready = 1'b0;
        perm_we = 1'b0;
        perm_wa = i_reg;
        perm_wd = cur_reg;
        perm_ra = i_reg;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                perm_we = load_new;
                perm_wa = SW'(count_reg);
                perm_wd = SW'(count_reg);
            end
            ST_RDJ:   perm_ra = j_reg;
            ST_SWAP: begin
                perm_we = 1'b1;
                perm_wa = j_reg;
            end
            ST_NEXTJ: perm_we = j_last;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (perm_we) begin
            perm_mem[perm_wa] <= perm_wd;
        end
        perm_q <= perm_mem[perm_ra];
        if (load_new) begin
            id_mem[SW'(count_reg)] <= s_record_id;
            st_mem[SW'(count_reg)] <= s_record_status;
        end
        id_q <= id_mem[perm_q];
        st_q <= st_mem[perm_q];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            open_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                count_reg <= count_after;
                if (s_record_end || s_set_end) begin
                    open_reg <= 1'b0;
                end else if (widx_zero) begin
                    open_reg <= room;
                end
                if (widx_zero && !room) begin
                    ovf_reg <= 1'b1;
                end else if (s_set_end && count_after == '0) begin
                    ovf_reg <= 1'b0;
                end
            end
            if (state_reg == ST_EOUT) begin
                m_valid_reg <= 1'b1;
            end
            if (state_reg == ST_EWAIT && m_ready) begin
                m_valid_reg <= 1'b0;
                if (emit_last) begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_LOAD:  i_reg <= '0;
            ST_GETI: begin
                cur_reg <= perm_q;
                j_reg   <= i_reg + SW'(1);
            end
            ST_GETB: begin
                b_reg <= perm_q;
                k_reg <= '0;
            end
            ST_CMPW: begin
                if (!cmp_res.gt && !cmp_res.done && k_reg != WLast) begin
                    k_reg <= k_reg + WW'(1);
                end
            end
            ST_SWAP:  cur_reg <= b_reg;
            ST_NEXTJ: begin
                if (!j_last) begin
                    j_reg <= j_reg + SW'(1);
                end else if (i_last) begin
                    i_reg <= '0;
                end else begin
                    i_reg <= i_reg + SW'(1);
                end
            end
            ST_EGET:  slot_reg <= perm_q;
            ST_EOUT: begin
                m_pos_reg  <= PosW'(slot_reg);
                m_id_reg   <= id_q;
                m_st_reg   <= st_q;
                m_last_reg <= emit_last;
                m_drop_reg <= ovf_reg;
            end
            ST_EWAIT: begin
                if (m_ready && !emit_last) begin
                    i_reg <= i_reg + SW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_load_position = m_pos_reg;
    assign m_out_id        = m_id_reg;
    assign m_out_status    = m_st_reg;
    assign m_last_result   = m_last_reg;
    assign m_dropped       = m_drop_reg;

    a_emit_only_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == ST_EWAIT))
        else $error("result held outside emit wait");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_RECORDS))
        else $error("record count above capacity");

    a_swap_after_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWAP) |-> ($past(state_reg) == ST_CMPW))
        else $error("swap without compare");

    a_j_above_i: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GETB) |-> (j_reg > i_reg))
        else $error("inner index not above outer index");

endmodule
